// ===== hdl/adcs_pkg.sv =====
`timescale 1ns / 1ps

package adcs_pkg;

  // Field widths fixed by the interface.
  localparam int CH_W        = 3;
  localparam int PTR_W       = CH_W + 1;
  localparam int SMP_W       = 10;
  localparam int MASK_W      = 8;
  localparam int STORE_DEPTH = 8;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 8;

  typedef enum logic [1:0] {
    OP_START  = 2'd0,
    OP_DONE   = 2'd1,
    OP_SELECT = 2'd2,
    OP_READ   = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_BUSY    = 2'd1,
    STAT_EMPTY   = 2'd2,
    STAT_IGNORED = 2'd3
  } status_t;

  // Operating mode codes. The fourth code behaves as one-shot.
  localparam logic [1:0] MODE_ONESHOT = 2'd0;
  localparam logic [1:0] MODE_CONT    = 2'd1;
  localparam logic [1:0] MODE_SCAN    = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_OP_MODE   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCAN_MASK = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SEARCH
  } state_t;

  // What the sequencer does with the answer of the channel search.
  typedef enum logic [1:0] {
    PH_START,
    PH_NEXT,
    PH_WRAP
  } phase_t;

  typedef struct packed {
    logic             go;
    logic [PTR_W-1:0] from;
  } srch_req_t;

  typedef struct packed {
    logic            done;
    logic            found;
    logic [CH_W-1:0] pos;
  } srch_rsp_t;

endpackage

// ===== hdl/adcs_search.sv =====
`timescale 1ns / 1ps

// Next-enabled-channel search, one channel examined per cycle.
module adcs_search
  import adcs_pkg::*;
#(
  parameter int CHANNELS = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [MASK_W-1:0] mask,
  input  srch_req_t         req,
  output srch_rsp_t         rsp
);

  localparam logic [PTR_W-1:0] CH_CNT = PTR_W'(CHANNELS);

  logic [PTR_W-1:0] ptr_r, ptr_nxt;
  logic             active_r, active_nxt;
  logic             in_range;
  logic             hit;

  assign in_range = ptr_r < CH_CNT;
  assign hit      = in_range && mask[ptr_r[CH_W-1:0]];

  always_comb begin
    rsp.done  = active_r && (!in_range || hit);
    rsp.found = active_r && hit;
    rsp.pos   = ptr_r[CH_W-1:0];
  end

  always_comb begin
    ptr_nxt    = ptr_r;
    active_nxt = active_r;
    if (req.go) begin
      ptr_nxt    = req.from;
      active_nxt = 1'b1;
    end else if (rsp.done) begin
      active_nxt = 1'b0;
    end else if (active_r) begin
      ptr_nxt = ptr_r + PTR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r    <= '0;
      active_r <= 1'b0;
    end else begin
      ptr_r    <= ptr_nxt;
      active_r <= active_nxt;
    end
  end

endmodule

// ===== hdl/adcs_store.sv =====
`timescale 1ns / 1ps

// Per-channel sample store, cleared by reset.
module adcs_store
  import adcs_pkg::*;
#(
  parameter int SAMPLE_BITS = 10
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   we,
  input  logic [CH_W-1:0]        waddr,
  input  logic [SAMPLE_BITS-1:0] wdata,
  input  logic [CH_W-1:0]        raddr,
  output logic [SAMPLE_BITS-1:0] rdata
);

  logic [SAMPLE_BITS-1:0] mem_r [STORE_DEPTH];

  assign rdata = mem_r[raddr];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < STORE_DEPTH; i++) begin
        mem_r[i] <= '0;
      end
    end else if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

endmodule

// ===== hdl/adc_channel_scan_sequencer.sv =====
`timescale 1ns / 1ps
// A request is taken at the edge where start is high and busy is low; its result is
// strobed on out_valid after the execute state, and for scan starts and scan samples
// only once the searches of the shared search unit (one position a cycle) have answered.
// Busy stays high until the result, so one request is handled at a time; start is taken
// again in the cycle the result is shown. The receiver cannot stall. Reset is synchronous,
// active low, and clears the control state of the sequencer, the configuration registers
// and every entry of the result store.
module adc_channel_scan_sequencer
  import adcs_pkg::*;
#(
  parameter int CHANNELS    = 8,
  parameter int SAMPLE_BITS = 10
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Request channel.
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            in_opcode,
  input  logic [CH_W-1:0]       in_channel,
  input  logic [SMP_W-1:0]      in_sample,
  // Result channel, one strobed cycle per request.
  output logic                  out_valid,
  output logic [1:0]            out_status,
  output logic [CH_W-1:0]       out_result_channel,
  output logic [SMP_W-1:0]      out_result_value,
  output logic                  out_set_valid,
  output logic                  out_converting,
  output logic [CH_W-1:0]       out_next_channel,
  // Configuration write port.
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam logic [PTR_W-1:0] CH_CNT = PTR_W'(CHANNELS);

  // Sequencer state.
  state_t state_r, state_nxt;
  phase_t phase_r, phase_nxt;

  // Latched request.
  opcode_t          op_r, op_nxt;
  logic [CH_W-1:0]  ch_r, ch_nxt;
  logic [SMP_W-1:0] smp_r, smp_nxt;

  // Configuration.
  logic [1:0]        op_mode_r;
  logic [MASK_W-1:0] scan_mask_r;

  // Architectural state of the converter control.
  logic [CH_W-1:0] mux_r, mux_nxt;
  logic [CH_W-1:0] target_r, target_nxt;
  logic            valid_r, valid_nxt;
  logic            pass_busy_r, pass_busy_nxt;
  logic            auto_r, auto_nxt;
  logic [1:0]      eff_mode_r, eff_mode_nxt;

  // Result registers.
  logic             out_valid_r, out_valid_nxt;
  status_t          out_status_r, out_status_nxt;
  logic [CH_W-1:0]  out_rch_r, out_rch_nxt;
  logic [SMP_W-1:0] out_rval_r, out_rval_nxt;

  // Store and search unit hookup.
  logic                   st_we;
  logic [SAMPLE_BITS-1:0] st_wdata;
  logic [SAMPLE_BITS-1:0] st_rdata;
  srch_req_t              srch_req;
  srch_rsp_t              srch_rsp;

  logic ch_ok;
  logic running;

  assign busy    = (state_r != ST_IDLE);
  assign ch_ok   = {1'b0, ch_r} < CH_CNT;
  assign running = pass_busy_r || auto_r;

  // The sample is kept at the configured precision; only its low bits are reported.
  assign st_wdata = SAMPLE_BITS'(smp_r);

  adcs_store #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_store (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (st_we),
    .waddr (mux_r),
    .wdata (st_wdata),
    .raddr (ch_r),
    .rdata (st_rdata)
  );

  adcs_search #(
    .CHANNELS (CHANNELS)
  ) u_search (
    .clk   (clk),
    .rst_n (rst_n),
    .mask  (scan_mask_r),
    .req   (srch_req),
    .rsp   (srch_rsp)
  );

  // Next state of the sequencer. A result strobe always returns it to idle.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        state_nxt = srch_req.go ? ST_SEARCH : ST_IDLE;
      end
      ST_SEARCH: begin
        if (out_valid_nxt) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and control outputs of the sequencer.
  always_comb begin
    op_nxt         = op_r;
    ch_nxt         = ch_r;
    smp_nxt        = smp_r;
    phase_nxt      = phase_r;
    mux_nxt        = mux_r;
    target_nxt     = target_r;
    valid_nxt      = valid_r;
    pass_busy_nxt  = pass_busy_r;
    auto_nxt       = auto_r;
    eff_mode_nxt   = eff_mode_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_rch_nxt    = out_rch_r;
    out_rval_nxt   = out_rval_r;
    st_we          = 1'b0;
    srch_req.go    = 1'b0;
    srch_req.from  = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          op_nxt  = opcode_t'(in_opcode);
          ch_nxt  = in_channel;
          smp_nxt = in_sample;
        end
      end

      ST_EXEC: begin
        // Most requests report their own channel and no sample.
        out_status_nxt = STAT_OK;
        out_rch_nxt    = ch_r;
        out_rval_nxt   = '0;
        out_valid_nxt  = 1'b1;
        unique case (op_r)
          OP_START: begin
            if (!ch_ok && op_mode_r != MODE_SCAN) begin
              out_status_nxt = STAT_IGNORED;
            end else if (pass_busy_r) begin
              out_status_nxt = STAT_BUSY;
            end else if (op_mode_r == MODE_SCAN) begin
              // The first enabled channel is found by the search unit.
              valid_nxt     = 1'b0;
              out_valid_nxt = 1'b0;
              srch_req.go   = 1'b1;
              srch_req.from = '0;
              phase_nxt     = PH_START;
            end else begin
              eff_mode_nxt  = (op_mode_r == MODE_CONT) ? MODE_CONT : MODE_ONESHOT;
              auto_nxt      = (op_mode_r == MODE_CONT);
              valid_nxt     = 1'b0;
              pass_busy_nxt = 1'b1;
              mux_nxt       = ch_r;
              target_nxt    = ch_r;
            end
          end

          OP_DONE: begin
            if (!running) begin
              out_status_nxt = STAT_IGNORED;
            end else begin
              st_we        = 1'b1;
              out_rch_nxt  = mux_r;
              out_rval_nxt = SMP_W'(st_wdata);
              if (eff_mode_r == MODE_SCAN) begin
                // Advance to the next enabled channel above the one just sampled.
                out_valid_nxt = 1'b0;
                srch_req.go   = 1'b1;
                srch_req.from = {1'b0, mux_r} + PTR_W'(1);
                phase_nxt     = PH_NEXT;
              end else if (eff_mode_r == MODE_CONT) begin
                // A pending channel change takes effect now; otherwise the result is stable.
                if (target_r != mux_r) begin
                  mux_nxt = target_r;
                end else begin
                  valid_nxt     = 1'b1;
                  pass_busy_nxt = 1'b0;
                end
              end else begin
                valid_nxt     = 1'b1;
                pass_busy_nxt = 1'b0;
                auto_nxt      = 1'b0;
              end
            end
          end

          OP_SELECT: begin
            if (!ch_ok || eff_mode_r != MODE_CONT) begin
              out_status_nxt = STAT_IGNORED;
            end else begin
              target_nxt    = ch_r;
              valid_nxt     = 1'b0;
              pass_busy_nxt = 1'b1;
            end
          end

          OP_READ: begin
            if (!ch_ok) begin
              out_status_nxt = STAT_IGNORED;
            end else if (eff_mode_r != MODE_ONESHOT && !valid_r) begin
              out_status_nxt = STAT_BUSY;
            end else begin
              out_rval_nxt = SMP_W'(st_rdata);
            end
          end

          default: out_status_nxt = STAT_IGNORED;
        endcase
      end

      ST_SEARCH: begin
        if (srch_rsp.done) begin
          out_valid_nxt = 1'b1;
          unique case (phase_r)
            PH_START: begin
              if (srch_rsp.found) begin
                eff_mode_nxt  = MODE_SCAN;
                auto_nxt      = 1'b1;
                pass_busy_nxt = 1'b1;
                mux_nxt       = srch_rsp.pos;
                target_nxt    = srch_rsp.pos;
                out_rch_nxt   = srch_rsp.pos;
              end else begin
                // Empty mask: fall back to idle one-shot operation.
                eff_mode_nxt   = MODE_ONESHOT;
                auto_nxt       = 1'b0;
                pass_busy_nxt  = 1'b0;
                mux_nxt        = '0;
                target_nxt     = '0;
                out_status_nxt = STAT_EMPTY;
                out_rch_nxt    = '0;
              end
            end

            PH_NEXT: begin
              if (srch_rsp.found) begin
                mux_nxt = srch_rsp.pos;
              end else begin
                // The pass wrapped: the set is complete, restart from the lowest channel.
                valid_nxt     = 1'b1;
                pass_busy_nxt = 1'b0;
                out_valid_nxt = 1'b0;
                srch_req.go   = 1'b1;
                srch_req.from = '0;
                phase_nxt     = PH_WRAP;
              end
            end

            PH_WRAP: begin
              if (srch_rsp.found) begin
                mux_nxt = srch_rsp.pos;
              end else begin
                // The mask was emptied during the scan.
                eff_mode_nxt  = MODE_ONESHOT;
                auto_nxt      = 1'b0;
                pass_busy_nxt = 1'b0;
                mux_nxt       = '0;
                target_nxt    = '0;
              end
            end

            default: out_valid_nxt = 1'b1;
          endcase
        end
      end

      default: out_valid_nxt = 1'b0;
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= PH_START;
      op_mode_r   <= MODE_ONESHOT;
      scan_mask_r <= '0;
      mux_r       <= '0;
      target_r    <= '0;
      valid_r     <= 1'b0;
      pass_busy_r <= 1'b0;
      auto_r      <= 1'b0;
      eff_mode_r  <= MODE_ONESHOT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      mux_r       <= mux_nxt;
      target_r    <= target_nxt;
      valid_r     <= valid_nxt;
      pass_busy_r <= pass_busy_nxt;
      auto_r      <= auto_nxt;
      eff_mode_r  <= eff_mode_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_OP_MODE:   op_mode_r   <= cfg_wdata[1:0];
          CFG_SCAN_MASK: scan_mask_r <= cfg_wdata[MASK_W-1:0];
          default:       op_mode_r   <= op_mode_r;
        endcase
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    ch_r         <= ch_nxt;
    smp_r        <= smp_nxt;
    out_status_r <= out_status_nxt;
    out_rch_r    <= out_rch_nxt;
    out_rval_r   <= out_rval_nxt;
  end

  // The state fields of a result are read straight from the control registers, which hold
  // the post-request values during the strobe cycle.
  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_result_channel = out_rch_r;
  assign out_result_value   = out_rval_r;
  assign out_set_valid      = valid_r;
  assign out_converting     = running;
  assign out_next_channel   = mux_r;

endmodule

// ===== verif/adc_seq_checker_pkg.sv =====
`timescale 1ns / 1ps

package adc_seq_checker_pkg;
  import adcs_pkg::*;

  typedef struct packed {
    status_t          status;
    logic [CH_W-1:0]  chan;
    logic [SMP_W-1:0] value;
    logic             set_valid;
    logic             converting;
    logic [CH_W-1:0]  next_ch;
  } adc_result_t;

  class adc_seq_checker;
    // Configuration as the sequencer holds it.
    logic [1:0]        op_mode;
    logic [MASK_W-1:0] scan_mask;

    // Sequencer state.
    logic [SMP_W-1:0]  sample_store [STORE_DEPTH];
    logic [CH_W-1:0]   mux_ch;
    logic [CH_W-1:0]   target_ch;
    logic              valid_flag;
    logic              pass_busy;
    logic              auto_repeat;
    logic [1:0]        run_mode;

    adc_result_t       pending_results [$];
    int                errors;
    int                n_requests;

    function new();
      op_mode = MODE_ONESHOT;
      scan_mask = '0;
      foreach (sample_store[i]) sample_store[i] = '0;
      mux_ch = '0;
      target_ch = '0;
      valid_flag = 1'b0;
      pass_busy = 1'b0;
      auto_repeat = 1'b0;
      run_mode = MODE_ONESHOT;
      errors = 0;
      n_requests = 0;
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == CFG_OP_MODE) op_mode = data[1:0];
      else scan_mask = data[MASK_W-1:0];
    endfunction

    // First channel enabled for scan at or above from; STORE_DEPTH if none.
    function int first_enabled(int from);
      int c;
      for (c = from; c < STORE_DEPTH; c++) begin
        if (scan_mask[c]) return c;
      end
      return STORE_DEPTH;
    endfunction

    function void go_idle();
      run_mode = MODE_ONESHOT;
      auto_repeat = 1'b0;
      pass_busy = 1'b0;
      mux_ch = '0;
      target_ch = '0;
    endfunction

    // Applies one accepted request to the state and queues the result it must give.
    function void accept_request(opcode_t op, logic [CH_W-1:0] ch, logic [SMP_W-1:0] smp);
      adc_result_t r;
      int nx;
      logic [CH_W-1:0] cur;
      r = '0;
      r.status = STAT_OK;
      r.chan = ch;
      case (op)
        OP_START: begin
          if (pass_busy) begin
            r.status = STAT_BUSY;
          end else if (op_mode == MODE_SCAN) begin
            nx = first_enabled(0);
            valid_flag = 1'b0;
            if (nx >= STORE_DEPTH) begin
              go_idle();
              r.status = STAT_EMPTY;
            end else begin
              run_mode = MODE_SCAN;
              auto_repeat = 1'b1;
              pass_busy = 1'b1;
              mux_ch = nx[CH_W-1:0];
              target_ch = nx[CH_W-1:0];
            end
            r.chan = mux_ch;
          end else begin
            run_mode = (op_mode == MODE_CONT) ? MODE_CONT : MODE_ONESHOT;
            auto_repeat = (op_mode == MODE_CONT);
            valid_flag = 1'b0;
            pass_busy = 1'b1;
            mux_ch = ch;
            target_ch = ch;
          end
        end
        OP_DONE: begin
          if (!(pass_busy || auto_repeat)) begin
            r.status = STAT_IGNORED;
          end else begin
            cur = mux_ch;
            sample_store[cur] = smp;
            r.chan = cur;
            r.value = smp;
            if (run_mode == MODE_SCAN) begin
              nx = first_enabled(int'(cur) + 1);
              if (nx >= STORE_DEPTH) begin
                valid_flag = 1'b1;
                pass_busy = 1'b0;
                nx = first_enabled(0);
              end
              if (nx >= STORE_DEPTH) go_idle();
              else mux_ch = nx[CH_W-1:0];
            end else if (run_mode == MODE_CONT) begin
              if (target_ch != mux_ch) begin
                mux_ch = target_ch;
              end else begin
                valid_flag = 1'b1;
                pass_busy = 1'b0;
              end
            end else begin
              valid_flag = 1'b1;
              pass_busy = 1'b0;
              auto_repeat = 1'b0;
            end
          end
        end
        OP_SELECT: begin
          if (run_mode != MODE_CONT) begin
            r.status = STAT_IGNORED;
          end else begin
            target_ch = ch;
            valid_flag = 1'b0;
            pass_busy = 1'b1;
          end
        end
        default: begin
          if (run_mode != MODE_ONESHOT && !valid_flag) r.status = STAT_BUSY;
          else r.value = sample_store[ch];
        end
      endcase
      r.set_valid = valid_flag;
      r.converting = pass_busy || auto_repeat;
      r.next_ch = mux_ch;
      pending_results.push_back(r);
      n_requests++;
    endfunction

    function void compare_field(string name, int expected, int actual);
      if (expected != actual) begin
        $error("%s: expected %0d, got %0d", name, expected, actual);
        errors++;
      end
    endfunction

    function void check_result(adc_result_t act);
      adc_result_t exp_r;
      if (pending_results.size() == 0) begin
        $error("result with no request outstanding (status %0d, channel %0d)",
               act.status, act.chan);
        errors++;
        return;
      end
      exp_r = pending_results.pop_front();
      compare_field("status", exp_r.status, act.status);
      compare_field("result_channel", exp_r.chan, act.chan);
      compare_field("result_value", exp_r.value, act.value);
      compare_field("set_valid", exp_r.set_valid, act.set_valid);
      compare_field("converting", exp_r.converting, act.converting);
      compare_field("next_channel", exp_r.next_ch, act.next_ch);
    endfunction
  endclass

endpackage

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import adcs_pkg::*;
  import adc_seq_checker_pkg::*;

  // The fourth mode code, which the sequencer must treat as one-shot.
  localparam logic [1:0] MODE_ONESHOT_ALT = 2'd3;
  // Margin above the worst case from a request to its result.
  localparam int SETTLE_CYCLES = 24;
  localparam int RANDOM_REQUESTS = 1850;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  logic [1:0]            in_opcode = '0;
  logic [CH_W-1:0]       in_channel = '0;
  logic [SMP_W-1:0]      in_sample = '0;
  logic                  out_valid;
  logic [1:0]            out_status;
  logic [CH_W-1:0]       out_result_channel;
  logic [SMP_W-1:0]      out_result_value;
  logic                  out_set_valid;
  logic                  out_converting;
  logic [CH_W-1:0]       out_next_channel;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  adc_seq_checker sb = new();

  always #1 clk = ~clk;

  adc_channel_scan_sequencer dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_opcode          (in_opcode),
    .in_channel         (in_channel),
    .in_sample          (in_sample),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_result_channel (out_result_channel),
    .out_result_value   (out_result_value),
    .out_set_valid      (out_set_valid),
    .out_converting     (out_converting),
    .out_next_channel   (out_next_channel),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata)
  );

  // Monitor. Everything here reads the values that stood before the edge, so it never
  // races the block's own updates. A result that shows up in the same cycle as a new
  // request belongs to an older request, so the check goes first.
  always @(posedge clk) begin
    adc_result_t act;
    if (rst_n) begin
      if (out_valid) begin
        act.status = status_t'(out_status);
        act.chan = out_result_channel;
        act.value = out_result_value;
        act.set_valid = out_set_valid;
        act.converting = out_converting;
        act.next_ch = out_next_channel;
        sb.check_result(act);
      end
      if (start && !busy) sb.accept_request(opcode_t'(in_opcode), in_channel, in_sample);
    end
  end

  // Issues one request after an idle gap of the given length. The task returns right
  // after the edge that took the request, with start still high: the next call either
  // presents its own request in the same step or drops start for its gap, so a request
  // is never taken twice and start is never lowered and raised within one step.
  task automatic send_request(opcode_t op, logic [CH_W-1:0] ch, logic [SMP_W-1:0] smp,
                              int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_opcode <= op;
    in_channel <= ch;
    in_sample <= smp;
    do @(posedge clk); while (busy);
  endtask

  // Drops start and lets every outstanding result come back, then gives the search
  // unit time to finish, so the block is truly quiet. Bounded so a hung block still
  // reaches the end and reports.
  task automatic settle();
    int waited;
    waited = 0;
    start <= 1'b0;
    while (sb.pending_results.size() != 0 && waited < 2000) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register writes only ever happen with the block quiet.
  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    settle();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    sb.write_register(idx, data);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [MASK_W-1:0] pick_mask();
    logic [MASK_W-1:0] m;
    case ($urandom_range(0, 3))
      0: m = '0;
      1: m = '1;
      2: m = 8'h01 << $urandom_range(0, 7);
      default: m = MASK_W'($urandom_range(0, 255));
    endcase
    return m;
  endfunction

  // One phase of random traffic. Conversion-done requests dominate so that scans wrap
  // and continuous mode sees channel changes land; starts, selects and reads are mixed
  // in, and a slice of fully random requests adds noise. Some phases run with no gaps.
  task automatic random_phase(int n);
    int i;
    int pick;
    int gap_max;
    opcode_t op;
    gap_max = ($urandom_range(0, 3) == 0) ? 0 : 7;
    for (i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 12) op = OP_START;
      else if (pick < 60) op = OP_DONE;
      else if (pick < 72) op = OP_SELECT;
      else if (pick < 92) op = OP_READ;
      else op = opcode_t'($urandom_range(0, 3));
      send_request(op, CH_W'($urandom_range(0, 7)), SMP_W'($urandom_range(0, 1023)),
                   $urandom_range(0, gap_max));
    end
  endtask

  // Directed opening, then random phases, each phase with fresh register settings.
  initial begin
    int base;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // One-shot straight out of reset: a read answers with the cleared store, a done with
    // nothing running and a select outside continuous mode are both ignored, and a second
    // start while the first conversion is pending is refused.
    send_request(OP_READ, 3'd0, 10'd0, 0);
    send_request(OP_DONE, 3'd1, 10'h3FF, 1);
    send_request(OP_SELECT, 3'd2, 10'd0, 0);
    send_request(OP_START, 3'd7, 10'd0, 2);
    send_request(OP_START, 3'd0, 10'd0, 0);
    send_request(OP_DONE, 3'd0, 10'h3FF, 0);
    send_request(OP_READ, 3'd7, 10'd0, 1);
    send_request(OP_START, 3'd0, 10'd0, 0);
    send_request(OP_DONE, 3'd5, 10'd0, 0);

    // Continuous: a read before the first sample is refused, and a select takes effect
    // only after the sample already under way.
    write_register(CFG_OP_MODE, CFG_DATA_W'(MODE_CONT));
    send_request(OP_START, 3'd3, 10'd0, 0);
    send_request(OP_READ, 3'd3, 10'd0, 0);
    send_request(OP_SELECT, 3'd5, 10'd0, 1);
    send_request(OP_DONE, 3'd0, 10'h155, 0);
    send_request(OP_DONE, 3'd0, 10'h2AA, 0);
    send_request(OP_READ, 3'd5, 10'd0, 0);

    // Scan with an empty mask falls back to idle one-shot.
    write_register(CFG_OP_MODE, CFG_DATA_W'(MODE_SCAN));
    write_register(CFG_SCAN_MASK, 8'h00);
    send_request(OP_START, 3'd4, 10'd0, 0);

    // Scan over the two outermost channels: the second sample wraps and marks the set.
    write_register(CFG_SCAN_MASK, 8'h81);
    send_request(OP_START, 3'd4, 10'd0, 0);
    send_request(OP_DONE, 3'd0, 10'h0F0, 0);
    send_request(OP_DONE, 3'd0, 10'h30F, 3);
    send_request(OP_READ, 3'd7, 10'd0, 0);

    // The mask is emptied while the scan keeps running: the next sample is still stored,
    // then the block drops back to idle.
    write_register(CFG_SCAN_MASK, 8'h00);
    send_request(OP_DONE, 3'd0, 10'h200, 0);

    // The spare mode code acts as one-shot.
    write_register(CFG_OP_MODE, CFG_DATA_W'(MODE_ONESHOT_ALT));
    send_request(OP_START, 3'd6, 10'd0, 0);
    send_request(OP_DONE, 3'd0, 10'h200, 0);
    send_request(OP_READ, 3'd6, 10'd0, 0);

    // Random phases. The scan state deliberately carries over from one phase to the next,
    // so new masks and modes also land on a sequencer that is still running.
    settle();
    base = sb.n_requests;
    while (sb.n_requests - base < RANDOM_REQUESTS) begin
      write_register(CFG_OP_MODE, CFG_DATA_W'($urandom_range(0, 3)));
      write_register(CFG_SCAN_MASK, pick_mask());
      random_phase($urandom_range(30, 70));
    end

    settle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.pending_results.size() != 0) begin
      $error("%0d results never arrived", sb.pending_results.size());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog, far above the slowest correct run.
  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== adc_channel_scan_sequencer.f =====
hdl/adcs_pkg.sv
hdl/adcs_search.sv
hdl/adcs_store.sv
hdl/adc_channel_scan_sequencer.sv
verif/adc_seq_checker_pkg.sv
verif/tb_top.sv
